### hdl/mwcs_pkg.sv
// Shared constants and widths for the motif window coverage scorer.
package mwcs_pkg;

    // Default sizes
    localparam int MAX_WINDOW_DEF    = 8;
    localparam int MAX_MOTIF_LEN_DEF = 64;

    // Fixed field widths
    localparam int BASE_W     = 2;
    localparam int WLEN_W     = 4;
    localparam int COV_W      = 7;
    localparam int LIMIT_W    = 4;
    localparam int START_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COV_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 2'd2;

    // Register reset values
    localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST     = 4'd4;
    localparam logic [COV_W-1:0]   COV_THRESHOLD_RST  = 7'd10;
    localparam logic [LIMIT_W-1:0] MISMATCH_LIMIT_RST = 4'd1;

    // Coverage saturation point
    localparam int COV_MAX = (1 << COV_W) - 1;

    // Output word bit positions, lowest field first
    localparam int M_HIT_LSB   = 0;
    localparam int M_START_LSB = 1;
    localparam int M_COV_LSB   = M_START_LSB + START_W;
    localparam int M_PASS_LSB  = M_COV_LSB + COV_W;

endpackage

### hdl/motif_window_coverage_scorer.sv
// Top level: motif window coverage scorer, one aligned base pair per word.
//
// Usage
//   s_* : one word per motif position. s_tdata[1:0] motif base,
//         s_tdata[3:2] instance base (A=0 G=1 C=2 T=3); s_tlast flags the
//         final position of the motif window.
//   m_* : exactly one result word per input word, in order. m_tlast echoes
//         the input's last flag and marks the final result of the instance.
//   cfg_*: register writes (index 0 window_len, 1 coverage_threshold,
//         2 mismatch_limit); cfg_ready is always high. Write only when idle.
// Output: a result is written into the output register at the edge that
//   accepts its input word.
// Throughput: one word per cycle while the output is not stalled. The mismatch
//   shift, windowed popcount, overlap add and saturation are all combinational
//   between the state registers and the output register.
// Stall: when the output word is held (m_tvalid high, m_tready low) s_tready
//   drops; nothing is lost and the held word stays stable.
// Reset: rst_n (async, active low) clears the run state and the output
//   valid flag and loads the register defaults (4, 10, 1). Each word with
//   tlast set also clears the run state after its result is formed.
module motif_window_coverage_scorer #(
    parameter int MAX_WINDOW    = mwcs_pkg::MAX_WINDOW_DEF,
    parameter int MAX_MOTIF_LEN = mwcs_pkg::MAX_MOTIF_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mwcs_pkg::S_DATA_W-1:0]       s_tdata,  // motif_base, instance_base, zero pad
    input  logic                                s_tlast,  // last_position
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwcs_pkg::M_DATA_W-1:0]       m_tdata,  // window_hit, window_start,
                                                          // coverage_so_far, instance_pass, pad
    output logic                                m_tlast,  // run_end
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WLW = $clog2(MAX_WINDOW + 1);     // effective window length
    localparam int PCW = $clog2(MAX_WINDOW + 1);     // popcount width
    localparam int CW  = $clog2(MAX_MOTIF_LEN + 1);  // position counter
    localparam int AW  = ((CW > mwcs_pkg::COV_W) ? CW : mwcs_pkg::COV_W) + 2;
    localparam int LW  = (PCW > mwcs_pkg::LIMIT_W) ? PCW : mwcs_pkg::LIMIT_W;

    // configuration registers
    logic [mwcs_pkg::WLEN_W-1:0]  window_len_reg;
    logic [mwcs_pkg::COV_W-1:0]   cov_threshold_reg;
    logic [mwcs_pkg::LIMIT_W-1:0] mismatch_limit_reg;

    // run state
    logic [MAX_WINDOW-1:0]         hist_reg, hist_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [mwcs_pkg::START_W-1:0]  last_start_reg, last_start_next;
    logic                          any_hit_reg, any_hit_next;
    logic [mwcs_pkg::COV_W-1:0]    cov_reg, cov_next;

    // output register
    logic                          out_valid_reg;
    logic                          hit_reg, hit_next;
    logic [mwcs_pkg::START_W-1:0]  start_reg, start_next;
    logic [mwcs_pkg::COV_W-1:0]    cov_out_reg;
    logic                          pass_reg, pass_next;
    logic                          last_reg;

    logic                          in_accept;
    logic                          mismatch;
    logic [WLW-1:0]                wl;
    logic [MAX_WINDOW-1:0]         wmask;
    logic [PCW-1:0]                ones;
    logic                          in_range;
    logic                          full;
    logic                          qualify;
    logic                          overlap;
    logic [AW-1:0]                 start_full;
    logic [AW-1:0]                 add;
    logic [AW-1:0]                 sum;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg     <= mwcs_pkg::WINDOW_LEN_RST;
            cov_threshold_reg  <= mwcs_pkg::COV_THRESHOLD_RST;
            mismatch_limit_reg <= mwcs_pkg::MISMATCH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mwcs_pkg::REG_WINDOW_LEN:
                    window_len_reg <= cfg_data[mwcs_pkg::WLEN_W-1:0];
                mwcs_pkg::REG_COV_THRESHOLD:
                    cov_threshold_reg <= cfg_data;
                mwcs_pkg::REG_MISMATCH_LIMIT:
                    mismatch_limit_reg <= cfg_data[mwcs_pkg::LIMIT_W-1:0];
                default:
                    ; // unmapped index: ignored
            endcase
        end
    end

    // ---------------- per-word datapath ----------------
    always_comb
    begin
        // effective window length: 0 acts as 1, clamp at MAX_WINDOW
        if (window_len_reg == '0)
            wl = WLW'(1);
        else if (int'(window_len_reg) > MAX_WINDOW)
            wl = WLW'(MAX_WINDOW);
        else
            wl = WLW'(window_len_reg);

        mismatch  = s_tdata[1:0] != s_tdata[3:2];
        hist_next = {hist_reg[MAX_WINDOW-2:0], mismatch};

        // mismatches inside the current sub-window
        ones = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            wmask[i] = (i < int'(wl));
            ones     = ones + PCW'(hist_next[i] & wmask[i]);
        end

        in_range   = int'(count_reg) < MAX_MOTIF_LEN;
        full       = (AW'(count_reg) + AW'(1)) >= AW'(wl);
        start_full = AW'(count_reg) + AW'(1) - AW'(wl);
        qualify    = in_range && full && (LW'(ones) <= LW'(mismatch_limit_reg));

        // union growth against the previous qualifying sub-window
        overlap = any_hit_reg &&
                  ((AW'(last_start_reg) + AW'(wl) - AW'(1)) >= start_full);
        if (overlap)
            add = (start_full > AW'(last_start_reg)) ?
                  (start_full - AW'(last_start_reg)) : '0;
        else
            add = AW'(wl);
        sum = AW'(cov_reg) + add;

        count_next      = count_reg;
        last_start_next = last_start_reg;
        any_hit_next    = any_hit_reg;
        cov_next        = cov_reg;
        hit_next        = 1'b0;
        start_next      = '0;

        if (in_range)
        begin
            count_next = count_reg + CW'(1);
            if (full)
                start_next = start_full[mwcs_pkg::START_W-1:0];
        end

        if (qualify)
        begin
            hit_next        = 1'b1;
            cov_next        = (sum > AW'(mwcs_pkg::COV_MAX)) ?
                              mwcs_pkg::COV_W'(mwcs_pkg::COV_MAX) :
                              sum[mwcs_pkg::COV_W-1:0];
            last_start_next = start_full[mwcs_pkg::START_W-1:0];
            any_hit_next    = 1'b1;
        end

        pass_next = s_tlast && (cov_next >= cov_threshold_reg);
    end

    // run state: cleared after the last word of an instance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg       <= '0;
            count_reg      <= '0;
            last_start_reg <= '0;
            any_hit_reg    <= 1'b0;
            cov_reg        <= '0;
        end
        else if (in_accept)
        begin
            if (s_tlast)
            begin
                hist_reg       <= '0;
                count_reg      <= '0;
                last_start_reg <= '0;
                any_hit_reg    <= 1'b0;
                cov_reg        <= '0;
            end
            else
            begin
                hist_reg       <= hist_next;
                count_reg      <= count_next;
                last_start_reg <= last_start_next;
                any_hit_reg    <= any_hit_next;
                cov_reg        <= cov_next;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hit_reg     <= hit_next;
            start_reg   <= start_next;
            cov_out_reg <= cov_next;
            pass_reg    <= pass_next;
            last_reg    <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, pass_reg, cov_out_reg, start_reg, hit_reg};

endmodule

### hdl/mwcs_checker.sv
// Port-level checks for the motif window coverage scorer, bound to the top level.
module mwcs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mwcs_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tlast
);

    // pass is only reported on the final word of an instance
    a_pass_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[mwcs_pkg::M_PASS_LSB] |-> m_tlast)
        else $error("instance_pass set on a non-final word");

    // every accepted input word yields a result word on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // a held output word blocks the input side
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output word is held");

    // stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

endmodule

bind motif_window_coverage_scorer mwcs_checker u_mwcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### dv/motif_window_coverage_scorer_tb.sv
// Self-checking testbench for the motif window coverage scorer.
`timescale 1ns / 1ps

module motif_window_coverage_scorer_tb;

    import mwcs_pkg::*;

    localparam int MAX_WIN = MAX_WINDOW_DEF;
    localparam int MAX_POS = MAX_MOTIF_LEN_DEF;
    // The limit leaves ample room for the slowest correct run, with both sides idling
    // and drain pauses per phase, over roughly 1300 words.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 100;
    localparam int RAND_PHASES = 12;
    // the last run of a phase overshoots this by about 18 words on average
    localparam int PHASE_WORDS = 86;

    // One aligned base pair as it goes into the stream.
    typedef struct packed {
        logic [BASE_W-1:0] motif;
        logic [BASE_W-1:0] cand;
        logic              last;
    } pair_t;

    // One scored result as it comes out.
    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] start;
        logic [COV_W-1:0]   cov;
        logic               pass;
        logic               run_end;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    motif_window_coverage_scorer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // motif_base, instance_base, zero pad
        .s_tlast   (s_tlast),   // last_position
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // window_hit, window_start, coverage_so_far, instance_pass
        .m_tlast   (m_tlast),   // run_end
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Words waiting to be driven, and the results they are expected to cause.
    pair_t  pair_q[$];
    score_t score_q[$];

    // Driver handshake bookkeeping
    logic word_taken = 1'b0;   // word on s_* was accepted at the last rising edge
    logic steady = 1'b0;       // no idling on either side while set

    // Predictor copy of the registers
    logic [WLEN_W-1:0]  win_len_reg = WINDOW_LEN_RST;
    logic [COV_W-1:0]   thr_reg     = COV_THRESHOLD_RST;
    logic [LIMIT_W-1:0] mm_lim_reg  = MISMATCH_LIMIT_RST;

    // Predictor copy of the run state
    logic [MAX_WIN-1:0] mm_hist = '0;   // newest mismatch in bit 0
    int                 pos_cnt = 0;
    int                 hit_start = 0;
    logic               hit_seen = 1'b0;
    int                 cov_total = 0;

    // Statistics
    int errors = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int passes_seen = 0;
    int runs_closed = 0;
    int overlong_runs = 0;
    int settings_used = 1;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Score one pair against the run state; advances that state.
    function automatic score_t score_pair(input pair_t p);
        score_t r;
        int     wl;
        int     pos;
        int     first;
        int     add;
        int     wmask;
        r = '0;
        // window length clamps into 1..MAX_WIN
        wl = (win_len_reg == 0) ? 1 : ((win_len_reg > MAX_WIN) ? MAX_WIN : int'(win_len_reg));
        mm_hist = {mm_hist[MAX_WIN-2:0], p.motif != p.cand};
        // past the longest motif the history still shifts but nothing is judged
        if (pos_cnt < MAX_POS)
        begin
            pos = pos_cnt;
            pos_cnt++;
            if (pos + 1 >= wl)
            begin
                first = pos + 1 - wl;
                r.start = first[START_W-1:0];
                wmask = (1 << wl) - 1;
                if ($countones(mm_hist & wmask[MAX_WIN-1:0]) <= mm_lim_reg)
                begin
                    r.hit = 1'b1;
                    // only the bases not already under the previous hit count
                    if (hit_seen && hit_start + wl - 1 >= first)
                        add = (first > hit_start) ? first - hit_start : 0;
                    else
                        add = wl;
                    cov_total = cov_total + add;
                    if (cov_total > COV_MAX)
                        cov_total = COV_MAX;
                    hit_start = first & 6'h3f;
                    hit_seen = 1'b1;
                end
            end
        end
        r.cov = cov_total[COV_W-1:0];
        r.run_end = p.last;
        if (p.last)
        begin
            r.pass = (cov_total >= thr_reg);
            mm_hist = '0;
            pos_cnt = 0;
            hit_start = 0;
            hit_seen = 1'b0;
            cov_total = 0;
        end
        return r;
    endfunction

    // Driver: presents the next pending word at the falling edge, with random gaps.
    always @(negedge clk)
    begin
        pair_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if (pair_q.size() != 0 && (steady || $urandom_range(99) >= 36))
                begin
                    nxt = pair_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W - 2*BASE_W){1'b0}}, nxt.cand, nxt.motif};
                    s_tlast  <= nxt.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= steady || ($urandom_range(99) >= 36);
        end
    end

    // Input side: every accepted word runs through the predictor.
    always @(posedge clk)
    begin
        pair_t p;
        if (rst_n)
        begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                p.motif = s_tdata[BASE_W-1:0];
                p.cand  = s_tdata[2*BASE_W-1:BASE_W];
                p.last  = s_tlast;
                score_q.insert(score_q.size(), score_pair(p));
                words_sent++;
            end
        end
    end

    // Monitor: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (score_q.size() == 0)
                    report_mismatch("result word with nothing expected", results_seen, -1);
                else
                begin
                    want = score_q.pop_front();
                    results_seen++;
                    if (m_tdata[M_HIT_LSB] !== want.hit)
                        report_mismatch("window_hit", m_tdata[M_HIT_LSB], want.hit);
                    if (m_tdata[M_START_LSB +: START_W] !== want.start)
                        report_mismatch("window_start", m_tdata[M_START_LSB +: START_W],
                                        want.start);
                    if (m_tdata[M_COV_LSB +: COV_W] !== want.cov)
                        report_mismatch("coverage_so_far", m_tdata[M_COV_LSB +: COV_W],
                                        want.cov);
                    if (m_tdata[M_PASS_LSB] !== want.pass)
                        report_mismatch("instance_pass", m_tdata[M_PASS_LSB], want.pass);
                    if (m_tlast !== want.run_end)
                        report_mismatch("run_end", m_tlast, want.run_end);
                    hits_seen += want.hit;
                    passes_seen += want.pass;
                    runs_closed += want.run_end;
                end
            end
        end
    end

    // Register write; leaves cfg_valid high so back-to-back writes need no extra edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WINDOW_LEN:     win_len_reg = val[WLEN_W-1:0];
            REG_COV_THRESHOLD:  thr_reg     = val[COV_W-1:0];
            REG_MISMATCH_LIMIT: mm_lim_reg  = val[LIMIT_W-1:0];
            default:            ;
        endcase
    endtask

    // Block until every queued word is in and every result is out, then let
    // the output register settle.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pair_q.size() != 0 || s_tvalid || score_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Queue one candidate run; miss_pct sets how often the bases differ.
    task automatic add_run(input int run_len, input int miss_pct, input bit closed);
        pair_t p;
        for (int k = 0; k < run_len; k++)
        begin
            p.motif = 2'($urandom_range(3));
            if ($urandom_range(99) < miss_pct)
                p.cand = p.motif + 2'($urandom_range(1, 3));
            else
                p.cand = p.motif;
            p.last = closed && (k == run_len - 1);
            pair_q.insert(pair_q.size(), p);
        end
    endtask

    // Register settings for the first phases, extremes first; later ones random.
    int wl_tab[5]  = '{1, 8, 0, 15, 3};
    int thr_tab[5] = '{0, 64, 127, 1, 20};
    int lim_tab[5] = '{0, 8, 15, 0, 2};

    initial
    begin
        pair_t p;
        int    phase_words;
        int    run_len;
        int    pick;
        int    miss_tab[5];
        miss_tab = '{0, 5, 15, 35, 100};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all sixteen base pairings as one run, reset settings.
        for (int k = 0; k < 16; k++)
        begin
            p.motif = 2'(k % 4);
            p.cand  = 2'(k / 4);
            p.last  = (k == 15);
            pair_q.insert(pair_q.size(), p);
        end
        // single-word run: window never fills, coverage stays below threshold
        p = '{motif: 2'd3, cand: 2'd3, last: 1'b1};
        pair_q.insert(pair_q.size(), p);
        // clean six-base run: overlapping hits, union coverage below threshold
        add_run(6, 0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < 5)
            begin
                write_reg(REG_WINDOW_LEN, wl_tab[ph]);
                write_reg(REG_COV_THRESHOLD, thr_tab[ph]);
                write_reg(REG_MISMATCH_LIMIT, lim_tab[ph]);
            end
            else
            begin
                write_reg(REG_WINDOW_LEN, $urandom_range(15));
                write_reg(REG_COV_THRESHOLD,
                          ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(40));
                write_reg(REG_MISMATCH_LIMIT,
                          ($urandom_range(5) == 0) ? $urandom_range(15) : $urandom_range(3));
            end
            @(negedge clk);
            cfg_valid <= 1'b0;
            settings_used++;
            // one phase runs with both sides always ready
            steady = (ph == 2);

            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    run_len = $urandom_range(1, 3);
                else if (pick < 85)
                    run_len = $urandom_range(4, 40);
                else if (pick < 95)
                    run_len = $urandom_range(41, MAX_POS);
                else
                begin
                    run_len = $urandom_range(MAX_POS + 1, MAX_POS + 8);
                    overlong_runs++;
                end
                // a run left open at the phase end carries over into new settings
                add_run(run_len, miss_tab[$urandom_range(4)],
                        !(phase_words + run_len >= PHASE_WORDS && $urandom_range(2) == 0));
                phase_words += run_len;
            end
            wait_drained();
        end
        steady = 1'b0;

        repeat (4) @(posedge clk);
        if (score_q.size() != 0)
            report_mismatch("results never delivered", 0, score_q.size());

        $display("covered %0d pair words over %0d register settings,",
                 words_sent, settings_used);
        $display("  %0d runs closed (%0d overlong); checked %0d results: %0d window hits,",
                 runs_closed, overlong_runs, results_seen, hits_seen);
        $display("  %0d passing runs, %0d mismatches", passes_seen, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
